>>> hdl/alnsum_pkg.sv
// Shared types, character constants and the classifier for the sequence summary block.
`timescale 1ns / 1ps
`default_nettype none
package alnsum_pkg;

  localparam int CountW     = 16;
  localparam int QueueDepth = 4;
  localparam int QueueIdxW  = $clog2(QueueDepth);

  localparam logic [7:0] ChDot   = 8'h2E;  // '.'
  localparam logic [7:0] ChDash  = 8'h2D;  // '-'
  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChC     = 8'h43;
  localparam logic [7:0] ChG     = 8'h47;
  localparam logic [7:0] ChT     = 8'h54;
  localparam logic [7:0] ChU     = 8'h55;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7A;
  localparam logic [7:0] CaseGap = 8'h20;

  typedef enum logic [2:0] {
    BASE_NONE = 3'd0,
    BASE_A    = 3'd1,
    BASE_C    = 3'd2,
    BASE_G    = 3'd3,
    BASE_T    = 3'd4,
    BASE_N    = 3'd5
  } base_code_t;

  typedef struct packed {
    base_code_t code;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [CountW-1:0] align_length;
    logic [CountW-1:0] base_count;
    logic [CountW-1:0] ambig_count;
    logic [CountW-1:0] longest_run;
    logic [CountW-1:0] first_base_pos;
    logic [CountW-1:0] last_base_pos;
  } summary_t;

  // Gap characters map to BASE_NONE; anything unlisted is an ambiguous base.
  function automatic base_code_t classify(input logic [7:0] ch);
    logic [7:0] up;
    base_code_t code;
    up = (ch >= ChLowA && ch <= ChLowZ) ? ch - CaseGap : ch;
    if (up == ChDot || up == ChDash) code = BASE_NONE;
    else if (up == ChA)              code = BASE_A;
    else if (up == ChC)              code = BASE_C;
    else if (up == ChG)              code = BASE_G;
    else if (up == ChT || up == ChU) code = BASE_T;
    else                             code = BASE_N;
    return code;
  endfunction

endpackage
`default_nettype wire

>>> hdl/alnsum_front.sv
// Front end: normalizes and classifies each incoming character into a queue entry.
`timescale 1ns / 1ps
`default_nettype none
module alnsum_front (
  input  wire logic [7:0]         char_in,
  input  wire logic               last,
  input  wire logic               push,
  input  wire logic               q_full,
  output alnsum_pkg::item_t       q_wdata,
  output logic                    q_wr
);

  always_comb begin
    q_wdata.code = alnsum_pkg::classify(char_in);
    q_wdata.last = last;
    q_wr         = push && !q_full;
  end

endmodule
`default_nettype wire

>>> hdl/alnsum_queue.sv
// Short register queue of classified items between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module alnsum_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr,
  input  wire alnsum_pkg::item_t  wdata,
  input  wire logic               rd,
  output alnsum_pkg::item_t       rdata,
  output logic                    full,
  output logic                    empty
);

  localparam int IdxW = alnsum_pkg::QueueIdxW;

  alnsum_pkg::item_t slots [alnsum_pkg::QueueDepth];
  logic [IdxW-1:0] wr_ptr;
  logic [IdxW-1:0] rd_ptr;
  logic [IdxW:0]   count;

  assign full  = (count == (IdxW+1)'(alnsum_pkg::QueueDepth));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/alnsum_back.sv
// Back end: running counts, run tracking and the registered summary beat.
`timescale 1ns / 1ps
`default_nettype none
module alnsum_back #(
  parameter int MAX_LEN = 65535
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire alnsum_pkg::item_t   q_rdata,
  input  wire logic                q_empty,
  output logic                     q_rd,
  input  wire logic                pop,
  output logic                     out_valid,
  output alnsum_pkg::summary_t     summary
);

  localparam int W = alnsum_pkg::CountW;
  localparam logic [W-1:0] SatCap =
    (MAX_LEN < 65535) ? W'(MAX_LEN) : {W{1'b1}};

  function automatic logic [W-1:0] sat_inc(input logic [W-1:0] v);
    return (v < SatCap) ? v + 1'b1 : SatCap;
  endfunction

  logic [W-1:0] position, bases_seen, ambig_seen, current_run, best_run;
  logic [W-1:0] first_pos, last_pos;
  alnsum_pkg::base_code_t previous_base;

  logic [W-1:0] position_next, bases_seen_next, ambig_seen_next;
  logic [W-1:0] current_run_next, best_run_next, first_pos_next, last_pos_next;
  alnsum_pkg::base_code_t previous_base_next;
  logic is_base;

  // A closing item waits only while the previous summary is still held.
  assign q_rd = !q_empty && (!q_rdata.last || !out_valid || pop);

  always_comb begin
    is_base            = (q_rdata.code != alnsum_pkg::BASE_NONE);
    position_next      = sat_inc(position);
    bases_seen_next    = bases_seen;
    ambig_seen_next    = ambig_seen;
    current_run_next   = current_run;
    best_run_next      = best_run;
    first_pos_next     = first_pos;
    last_pos_next      = last_pos;
    previous_base_next = previous_base;
    if (is_base) begin
      bases_seen_next = sat_inc(bases_seen);
      if (q_rdata.code == alnsum_pkg::BASE_N) ambig_seen_next = sat_inc(ambig_seen);
      if (first_pos == '0) first_pos_next = position_next;
      last_pos_next = position_next;
      if (previous_base != alnsum_pkg::BASE_NONE && q_rdata.code == previous_base) begin
        current_run_next = sat_inc(current_run);
      end else begin
        current_run_next = W'(1);
      end
      if (current_run_next > best_run) best_run_next = current_run_next;
      previous_base_next = q_rdata.code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      bases_seen    <= '0;
      ambig_seen    <= '0;
      current_run   <= '0;
      best_run      <= W'(1);
      first_pos     <= '0;
      last_pos      <= '0;
      previous_base <= alnsum_pkg::BASE_NONE;
      out_valid     <= 1'b0;
    end else begin
      if (q_rd && q_rdata.last) begin
        position      <= '0;
        bases_seen    <= '0;
        ambig_seen    <= '0;
        current_run   <= '0;
        best_run      <= W'(1);
        first_pos     <= '0;
        last_pos      <= '0;
        previous_base <= alnsum_pkg::BASE_NONE;
        out_valid     <= 1'b1;
      end else begin
        if (q_rd) begin
          position      <= position_next;
          bases_seen    <= bases_seen_next;
          ambig_seen    <= ambig_seen_next;
          current_run   <= current_run_next;
          best_run      <= best_run_next;
          first_pos     <= first_pos_next;
          last_pos      <= last_pos_next;
          previous_base <= previous_base_next;
        end
        if (pop) out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd && q_rdata.last) begin
      summary.align_length   <= position_next;
      summary.base_count     <= bases_seen_next;
      summary.ambig_count    <= ambig_seen_next;
      summary.longest_run    <= best_run_next;
      summary.first_base_pos <= first_pos_next;
      summary.last_base_pos  <= last_pos_next;
    end
  end

endmodule
`default_nettype wire

>>> hdl/aligned_sequence_summary.sv
// Top level of the aligned sequence summary block.
// One character beat is taken per clock while full is low; the back end retires one queued
// beat per clock except while a last-flagged beat waits on an unpopped summary, so sustained
// throughput is one character per cycle while summaries are popped. A character's effect
// reaches the summary through the queue write, then the accumulator update; the summary
// for a sequence shows on the result ports from the same edge at which its last character
// leaves the queue, and is held until popped. While an unpopped summary is held, the next
// last-flagged character waits at the head of the four-entry queue; characters behind it
// fill the queue and then full rises. Counts saturate at the lesser of MAX_LEN and 65535.
`timescale 1ns / 1ps
`default_nettype none
module aligned_sequence_summary #(
  parameter int MAX_LEN = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  char_in,
  input  wire logic        last,
  input  wire logic        push,
  output logic             full,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      align_length,
  output logic [15:0]      base_count,
  output logic [15:0]      ambig_count,
  output logic [15:0]      longest_run,
  output logic [15:0]      first_base_pos,
  output logic [15:0]      last_base_pos
);

  alnsum_pkg::item_t    q_wdata;
  alnsum_pkg::item_t    q_rdata;
  alnsum_pkg::summary_t summary;
  logic q_wr, q_rd, q_empty, out_valid;

  alnsum_front u_front (
    .char_in (char_in),
    .last    (last),
    .push    (push),
    .q_full  (full),
    .q_wdata (q_wdata),
    .q_wr    (q_wr)
  );

  alnsum_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .full  (full),
    .empty (q_empty)
  );

  alnsum_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_rdata   (q_rdata),
    .q_empty   (q_empty),
    .q_rd      (q_rd),
    .pop       (pop),
    .out_valid (out_valid),
    .summary   (summary)
  );

  assign empty          = !out_valid;
  assign align_length   = summary.align_length;
  assign base_count     = summary.base_count;
  assign ambig_count    = summary.ambig_count;
  assign longest_run    = summary.longest_run;
  assign first_base_pos = summary.first_base_pos;
  assign last_base_pos  = summary.last_base_pos;

endmodule
`default_nettype wire

>>> hdl/alnsum_checker.sv
// Port-level checker for the sequence summary block and its bind.
`timescale 1ns / 1ps
`default_nettype none
module alnsum_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [15:0] align_length,
  input wire logic [15:0] base_count,
  input wire logic [15:0] ambig_count,
  input wire logic [15:0] longest_run,
  input wire logic [15:0] first_base_pos,
  input wire logic [15:0] last_base_pos
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(align_length) && $stable(longest_run)))
    else $error("held summary beat changed");

  a_counts: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (align_length != 16'd0 && longest_run != 16'd0 &&
                base_count <= align_length && ambig_count <= base_count &&
                last_base_pos <= align_length && first_base_pos <= last_base_pos))
    else $error("summary counts inconsistent");

  a_no_bases: assert property (@(posedge clk) disable iff (rst)
    (!empty && base_count == 16'd0) |->
      (first_base_pos == 16'd0 && last_base_pos == 16'd0 && longest_run == 16'd1))
    else $error("empty sequence reports base positions");

endmodule

bind aligned_sequence_summary alnsum_checker u_alnsum_checker (.*);
`default_nettype wire

>>> tb/tb_aligned_sequence_summary.sv
// Self-checking testbench for the aligned sequence summary block.
`timescale 1ns / 1ps
module tb_aligned_sequence_summary;

  localparam int SatMax      = 65535;
  localparam int ResetCycles = 12;
  localparam int RandomChars = 750;
  localparam int LongChars   = 60;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 16;
  localparam int CycleLimit  = 1_000_000;
  localparam int NumRows     = 23;

  localparam logic [79:0] Nucleotides = "ACGTacgtUu";

  typedef struct packed {
    logic [7:0]           ch;
    logic                 lst;
    logic                 typed;
    alnsum_pkg::summary_t want;
  } dir_row_t;

  // Single-character sequences carry their summary inline; the longer one goes
  // through the predictor.
  dir_row_t directed_rows [NumRows] = '{
    '{"-",   1'b1, 1'b1, {16'd1, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0}},
    '{"A",   1'b1, 1'b1, {16'd1, 16'd1, 16'd0, 16'd1, 16'd1, 16'd1}},
    '{8'hFF, 1'b1, 1'b1, {16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1}},
    '{8'h00, 1'b1, 1'b1, {16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1}},
    '{"u",   1'b1, 1'b1, {16'd1, 16'd1, 16'd0, 16'd1, 16'd1, 16'd1}},
    '{".",   1'b0, 1'b0, 96'd0},
    '{"a",   1'b0, 1'b0, 96'd0},
    '{"u",   1'b0, 1'b0, 96'd0},
    '{"T",   1'b0, 1'b0, 96'd0},
    '{"t",   1'b0, 1'b0, 96'd0},
    '{"-",   1'b0, 1'b0, 96'd0},
    '{"g",   1'b0, 1'b0, 96'd0},
    '{"C",   1'b0, 1'b0, 96'd0},
    '{"c",   1'b0, 1'b0, 96'd0},
    '{"G",   1'b0, 1'b0, 96'd0},
    '{"n",   1'b0, 1'b0, 96'd0},
    '{"N",   1'b0, 1'b0, 96'd0},
    '{"x",   1'b0, 1'b0, 96'd0},
    '{8'h80, 1'b0, 1'b0, 96'd0},
    '{"z",   1'b0, 1'b0, 96'd0},
    '{8'h60, 1'b0, 1'b0, 96'd0},
    '{8'h7B, 1'b0, 1'b0, 96'd0},
    '{".",   1'b1, 1'b0, 96'd0}
  };

  string field_names [6] = '{"align_length", "base_count", "ambig_count",
                             "longest_run", "first_base_pos", "last_base_pos"};

  logic        clk = 1'b0;
  logic        rst;
  logic [7:0]  char_in;
  logic        last;
  logic        push;
  logic        full;
  logic        empty;
  logic        pop;
  logic [15:0] align_length;
  logic [15:0] base_count;
  logic [15:0] ambig_count;
  logic [15:0] longest_run;
  logic [15:0] first_base_pos;
  logic [15:0] last_base_pos;

  // Running summary of the sequence in flight
  int                     seq_pos;
  int                     seq_bases;
  int                     seq_ambig;
  int                     run_len;
  int                     run_best;
  int                     first_at;
  int                     last_at;
  alnsum_pkg::base_code_t run_base;

  alnsum_pkg::summary_t pending_summaries [$];

  int errors       = 0;
  int chars_sent   = 0;
  int results_seen = 0;
  int stall_cycles = 0;
  int cycle_count  = 0;
  bit send_idle    = 1'b1;
  bit recv_idle    = 1'b1;
  bit hold_pop     = 1'b0;

  always #10 clk = ~clk;

  aligned_sequence_summary i_dut (
    .clk            (clk),
    .rst            (rst),
    .char_in        (char_in),
    .last           (last),
    .push           (push),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .align_length   (align_length),
    .base_count     (base_count),
    .ambig_count    (ambig_count),
    .longest_run    (longest_run),
    .first_base_pos (first_base_pos),
    .last_base_pos  (last_base_pos)
  );

  function automatic alnsum_pkg::base_code_t base_of(input logic [7:0] ch);
    logic [7:0] up;
    alnsum_pkg::base_code_t b;
    up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
    case (up)
      ".", "-": b = alnsum_pkg::BASE_NONE;
      "A":      b = alnsum_pkg::BASE_A;
      "C":      b = alnsum_pkg::BASE_C;
      "G":      b = alnsum_pkg::BASE_G;
      "T", "U": b = alnsum_pkg::BASE_T;
      default:  b = alnsum_pkg::BASE_N;
    endcase
    return b;
  endfunction

  function automatic int sat_inc(input int v);
    return (v < SatMax) ? v + 1 : SatMax;
  endfunction

  task automatic clear_summary();
    seq_pos   = 0;
    seq_bases = 0;
    seq_ambig = 0;
    run_len   = 0;
    run_best  = 1;
    run_base  = alnsum_pkg::BASE_NONE;
    first_at  = 0;
    last_at   = 0;
  endtask

  task automatic accumulate(input logic [7:0] ch, input logic lst,
                            output alnsum_pkg::summary_t s);
    alnsum_pkg::base_code_t b;
    b = base_of(ch);
    seq_pos = sat_inc(seq_pos);
    if (b != alnsum_pkg::BASE_NONE) begin
      seq_bases = sat_inc(seq_bases);
      if (b == alnsum_pkg::BASE_N) seq_ambig = sat_inc(seq_ambig);
      if (first_at == 0) first_at = seq_pos;
      last_at = seq_pos;
      // gaps do not break a run
      run_len = (run_base == b) ? sat_inc(run_len) : 1;
      if (run_len > run_best) run_best = run_len;
      run_base = b;
    end
    s = {seq_pos[15:0], seq_bases[15:0], seq_ambig[15:0], run_best[15:0],
         first_at[15:0], last_at[15:0]};
    if (lst) clear_summary();
  endtask

  function automatic logic [7:0] draw_char(input logic [7:0] prev);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return prev;
    if (pick < 65) return Nucleotides[8 * $urandom_range(0, 9) +: 8];
    if (pick < 80) return $urandom_range(0, 1) ? "." : "-";
    if (pick < 88) return $urandom_range(0, 1) ? "N" : "n";
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic put_char(input logic [7:0] ch, input logic lst, input logic typed,
                          input alnsum_pkg::summary_t want);
    int gap;
    alnsum_pkg::summary_t s;
    gap = send_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    char_in <= ch;
    last    <= lst;
    // full only moves on the rising edge, so the falling edge sees what the edge will use
    @(negedge clk);
    while (full) begin
      stall_cycles++;
      @(negedge clk);
    end
    @(posedge clk);
    accumulate(ch, lst, s);
    chars_sent++;
    if (lst) pending_summaries.push_back(typed ? want : s);
  endtask

  task automatic stream_long(input logic [7:0] body, input logic [7:0] tail);
    int k;
    for (k = 0; k < LongChars; k++) put_char(body, 1'b0, 1'b0, '0);
    put_char(tail, 1'b1, 1'b0, '0);
  endtask

  task automatic check_summary();
    alnsum_pkg::summary_t got;
    alnsum_pkg::summary_t want;
    int f;
    got = {align_length, base_count, ambig_count, longest_run, first_base_pos,
           last_base_pos};
    results_seen++;
    if (pending_summaries.size() == 0) begin
      errors++;
      $display("%0t: summary with no sequence pending, expected none, actual %h", $time, got);
    end else begin
      want = pending_summaries.pop_front();
      for (f = 0; f < 6; f++) begin
        if (want[95 - 16 * f -: 16] !== got[95 - 16 * f -: 16]) begin
          errors++;
          $display("%0t: %s expected %0d actual %0d", $time, field_names[f],
                   want[95 - 16 * f -: 16], got[95 - 16 * f -: 16]);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : result_side
    int gap;
    pop <= 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_pop) gap = HoldCycles;
      else gap = recv_idle ? $urandom_range(0, 11) : 0;
      hold_pop = 1'b0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(negedge clk);
      while (empty) @(negedge clk);
      check_summary();
      @(posedge clk);
    end
  end

  initial begin : char_side
    int i;
    int k;
    int len;
    int rand_chars;
    logic [7:0] ch;
    logic [7:0] prev_ch;
    rst     <= 1'b1;
    push    <= 1'b0;
    char_in <= 8'd0;
    last    <= 1'b0;
    clear_summary();
    rand_chars = 0;
    prev_ch    = "A";
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < NumRows; i++)
      put_char(directed_rows[i].ch, directed_rows[i].lst, directed_rows[i].typed,
               directed_rows[i].want);

    // long sequences: one long run, all ambiguous, and a single base at the tail
    send_idle = 1'b0;
    recv_idle = 1'b0;
    stream_long("A", "A");
    stream_long("n", "n");
    stream_long(".", "C");

    // result side stalls while short sequences pile up behind it
    hold_pop = 1'b1;
    for (k = 0; k < 60; k++) begin
      ch = draw_char(prev_ch);
      prev_ch = ch;
      put_char(ch, $urandom_range(0, 2) == 0, 1'b0, '0);
      rand_chars++;
    end
    if (last !== 1'b1) begin
      put_char("G", 1'b1, 1'b0, '0);
      rand_chars++;
    end

    while (rand_chars < RandomChars) begin
      send_idle = $urandom_range(0, 3) != 0;
      recv_idle = $urandom_range(0, 3) != 0;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 16);
      for (k = 0; k < len; k++) begin
        ch = draw_char(prev_ch);
        prev_ch = ch;
        put_char(ch, k == len - 1, 1'b0, '0);
        rand_chars++;
      end
    end
    push <= 1'b0;

    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Streamed %0d characters: directed cases, three long sequences of %0d,",
             chars_sent, LongChars + 1);
    $display("and random sequences; %0d summaries checked, %0d cycles held off by full.",
             results_seen, stall_cycles);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
